// ===== design/bts_pkg.sv =====
`default_nettype none
package bts_pkg;

  localparam int TEMP_WIDTH = 12;
  localparam int OFS_WIDTH  = 8;
  localparam int CNT_WIDTH  = 4;
  localparam int STEP_WIDTH = 8;

  localparam int TEMP_MIN = -(2 ** (TEMP_WIDTH - 1));
  localparam int TEMP_MAX = (2 ** (TEMP_WIDTH - 1)) - 1;

  // stream data width, padded to whole bytes
  localparam int TDATA_WIDTH = ((TEMP_WIDTH + 7) / 8) * 8;

  // APB
  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 5;
  localparam int REG_IDX_WIDTH  = 3;

  localparam logic [REG_IDX_WIDTH-1:0] REG_VALID_MIN = 3'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_VALID_MAX = 3'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_OFFSET    = 3'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_WARMUP    = 3'd3;
  localparam logic [REG_IDX_WIDTH-1:0] REG_MAX_STEP  = 3'd4;

  typedef logic signed [TEMP_WIDTH-1:0] temp_t;
  typedef logic signed [OFS_WIDTH-1:0]  ofs_t;
  typedef logic        [CNT_WIDTH-1:0]  cnt_t;
  typedef logic        [STEP_WIDTH-1:0] step_t;

  typedef struct packed {
    temp_t valid_min;
    temp_t valid_max;
    ofs_t  offset;
    cnt_t  warmup_reads;
    step_t max_step;
  } cfg_t;

  typedef struct packed {
    temp_t value;
    logic  has_value;
    cnt_t  count;
  } state_t;

  localparam temp_t RST_VALID_MIN = TEMP_WIDTH'(200);
  localparam temp_t RST_VALID_MAX = TEMP_WIDTH'(450);
  localparam ofs_t  RST_OFFSET    = OFS_WIDTH'(30);
  localparam cnt_t  RST_WARMUP    = CNT_WIDTH'(3);
  localparam step_t RST_MAX_STEP  = STEP_WIDTH'(2);

endpackage
`default_nettype wire

// ===== design/bts_cfg.sv =====
`default_nettype none
module bts_cfg (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [bts_pkg::APB_ADDR_WIDTH-1:0]   paddr,
  input  wire logic [bts_pkg::APB_DATA_WIDTH-1:0]   pwdata,
  output logic      [bts_pkg::APB_DATA_WIDTH-1:0]   prdata,
  output logic                                      pready,
  output bts_pkg::cfg_t                             cfg
);
  import bts_pkg::*;

  cfg_t                     cfg_r;
  logic                     wr_en;
  logic [REG_IDX_WIDTH-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[APB_ADDR_WIDTH-1:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.valid_min    <= RST_VALID_MIN;
      cfg_r.valid_max    <= RST_VALID_MAX;
      cfg_r.offset       <= RST_OFFSET;
      cfg_r.warmup_reads <= RST_WARMUP;
      cfg_r.max_step     <= RST_MAX_STEP;
    end else if (wr_en) begin
      unique case (idx)
        REG_VALID_MIN: cfg_r.valid_min    <= pwdata[TEMP_WIDTH-1:0];
        REG_VALID_MAX: cfg_r.valid_max    <= pwdata[TEMP_WIDTH-1:0];
        REG_OFFSET:    cfg_r.offset       <= pwdata[OFS_WIDTH-1:0];
        REG_WARMUP:    cfg_r.warmup_reads <= pwdata[CNT_WIDTH-1:0];
        REG_MAX_STEP:  cfg_r.max_step     <= pwdata[STEP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_VALID_MIN: prdata = APB_DATA_WIDTH'(cfg_r.valid_min);
      REG_VALID_MAX: prdata = APB_DATA_WIDTH'(cfg_r.valid_max);
      REG_OFFSET:    prdata = APB_DATA_WIDTH'(cfg_r.offset);
      REG_WARMUP:    prdata = APB_DATA_WIDTH'(cfg_r.warmup_reads);
      REG_MAX_STEP:  prdata = APB_DATA_WIDTH'(cfg_r.max_step);
      default:       prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/bts_update.sv =====
`default_nettype none
module bts_update (
  input  wire bts_pkg::cfg_t    cfg,
  input  wire bts_pkg::state_t  st,
  input  wire bts_pkg::temp_t   reading,
  input  wire logic             reading_ok,
  output bts_pkg::state_t       st_nxt,
  output bts_pkg::temp_t        res_value,
  output logic                  res_valid
);
  import bts_pkg::*;

  localparam int SW = TEMP_WIDTH + 1;  // sum of two temps
  localparam int EW = TEMP_WIDTH + 4;  // 7*prev + new
  localparam int DW = TEMP_WIDTH + 2;  // slew compare

  localparam logic signed [SW-1:0] MIN_EXT = SW'(TEMP_MIN);
  localparam logic signed [SW-1:0] MAX_EXT = SW'(TEMP_MAX);

  logic                 reject;
  logic signed [SW-1:0] sum;
  temp_t                corr;
  logic signed [SW-1:0] avg_sum;
  logic signed [SW-1:0] avg_adj;
  temp_t                avg;
  logic signed [EW-1:0] prev_e;
  logic signed [EW-1:0] ema_sum;
  logic signed [EW-1:0] ema_adj;
  temp_t                target;
  logic signed [DW-1:0] prev_d;
  logic signed [DW-1:0] tgt_d;
  logic signed [DW-1:0] step_d;
  logic signed [DW-1:0] up_d;
  logic signed [DW-1:0] dn_d;
  temp_t                slewed;
  logic                 warming;

  assign reject = !reading_ok || (reading < cfg.valid_min) || (reading > cfg.valid_max);

  always_comb begin
    sum = SW'(reading) + SW'(cfg.offset);
    if (sum > SW'(cfg.valid_max)) begin
      corr = cfg.valid_max;
    end else if (sum > MAX_EXT) begin
      corr = TEMP_WIDTH'(TEMP_MAX);
    end else if (sum < MIN_EXT) begin
      corr = TEMP_WIDTH'(TEMP_MIN);
    end else begin
      corr = sum[TEMP_WIDTH-1:0];
    end
  end

  // pairwise average, truncated toward zero
  assign avg_sum = SW'(st.value) + SW'(corr);
  assign avg_adj = avg_sum + {{(SW-1){1'b0}}, avg_sum[SW-1]};
  assign avg     = avg_adj[TEMP_WIDTH:1];

  // (7*prev + new) / 8, truncated toward zero
  assign prev_e  = EW'(st.value);
  assign ema_sum = (prev_e <<< 3) - prev_e + EW'(corr);
  assign ema_adj = ema_sum + (ema_sum[EW-1] ? EW'(7) : EW'(0));
  assign target  = ema_adj[TEMP_WIDTH+2:3];

  assign prev_d = DW'(st.value);
  assign tgt_d  = DW'(target);
  assign step_d = $signed({{(DW-STEP_WIDTH){1'b0}}, cfg.max_step});
  assign up_d   = prev_d + step_d;
  assign dn_d   = prev_d - step_d;

  always_comb begin
    if (tgt_d > up_d) begin
      slewed = up_d[TEMP_WIDTH-1:0];
    end else if (tgt_d + step_d < prev_d) begin
      slewed = dn_d[TEMP_WIDTH-1:0];
    end else begin
      slewed = target;
    end
  end

  assign warming = st.count < cfg.warmup_reads;

  always_comb begin
    st_nxt    = st;
    res_valid = st.has_value;
    if (!reject) begin
      st_nxt.has_value = 1'b1;
      if (warming) begin
        st_nxt.count = st.count + CNT_WIDTH'(1);
        st_nxt.value = st.has_value ? avg : corr;
        res_valid    = 1'b0;
      end else begin
        st_nxt.value = st.has_value ? slewed : corr;
        res_valid    = 1'b1;
      end
    end
    res_value = res_valid ? st_nxt.value : '0;
  end

endmodule
`default_nettype wire

// ===== design/body_temperature_smoother.sv =====
// An accepted word enters the input register, its result the result register.
// Throughput: one word per cycle unless out_tready stalls; input and result
// registers form a two-stage pipeline with the update logic between them.
// Reset (synchronous, rst_n low): pipeline emptied, smoothed value, has-value
// flag and warm-up count cleared, registers back to their reset values.
`default_nettype none
module body_temperature_smoother (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [bts_pkg::TDATA_WIDTH-1:0]     in_tdata,   // [11:0] reading_x10
  input  wire logic                                in_tuser,   // [0] reading_ok
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [bts_pkg::TDATA_WIDTH-1:0]     out_tdata,  // [11:0] smoothed_x10
  output logic                                     out_tuser,  // [0] smoothed_valid
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [bts_pkg::APB_ADDR_WIDTH-1:0]  cfg_paddr,
  input  wire logic [bts_pkg::APB_DATA_WIDTH-1:0]  cfg_pwdata,
  output logic      [bts_pkg::APB_DATA_WIDTH-1:0]  cfg_prdata,
  output logic                                     cfg_pready
);
  import bts_pkg::*;

  cfg_t   cfg;
  state_t st_r;
  state_t st_nxt;
  temp_t  res_value;
  logic   res_valid;

  logic   s1_valid_r;
  temp_t  s1_reading_r;
  logic   s1_ok_r;
  logic   out_valid_r;
  temp_t  out_value_r;
  logic   out_flag_r;

  logic   out_load;
  logic   s1_adv;

  bts_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  bts_update u_update (
    .cfg        (cfg),
    .st         (st_r),
    .reading    (s1_reading_r),
    .reading_ok (s1_ok_r),
    .st_nxt     (st_nxt),
    .res_value  (res_value),
    .res_valid  (res_valid)
  );

  assign out_load  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_load;
  assign in_tready = !s1_valid_r || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_reading_r <= in_tdata[TEMP_WIDTH-1:0];
      s1_ok_r      <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_adv) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_value_r <= res_value;
      out_flag_r  <= res_valid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_WIDTH'(unsigned'(out_value_r));
  assign out_tuser  = out_flag_r;

  // a result marked not valid carries a zero value
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("invalid result with nonzero value");

  // any counted reading has stored a value
  a_count_has: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.count != '0) |-> st_r.has_value)
    else $error("warm-up count without stored value");

  // an item leaving the input register shows up as a result next cycle
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced item lost");

endmodule
`default_nettype wire

// ===== test/body_temperature_smoother_tb.sv =====
`timescale 1ns / 100ps
module body_temperature_smoother_tb;
  import bts_pkg::*;

  typedef struct {
    temp_t value;
    logic  valid;
  } smooth_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [TDATA_WIDTH-1:0] in_tdata = '0;     // [11:0] reading_x10
  logic in_tuser = 1'b0;                     // [0] reading_ok
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TDATA_WIDTH-1:0] out_tdata;         // [11:0] smoothed_x10
  logic out_tuser;                           // [0] smoothed_valid
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [APB_ADDR_WIDTH-1:0] cfg_paddr = '0;
  logic [APB_DATA_WIDTH-1:0] cfg_pwdata = '0;
  logic [APB_DATA_WIDTH-1:0] cfg_prdata;
  logic cfg_pready;

  // predictor copy of the registers and the smoothing state
  int win_min = 200;
  int win_max = 450;
  int offset = 30;
  int warmup = 3;
  int step_limit = 2;
  int smooth_value = 0;
  bit has_value = 1'b0;
  int warm_count = 0;

  smooth_result_t results_due[$];
  int errors = 0;
  int readings_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int settings_run = 0;
  bit quiet = 1'b0;
  int hold_req = 0;
  int hold_left = 0;

  body_temperature_smoother u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic smooth_result_t smooth_next(temp_t reading, logic ok);
    smooth_result_t res;
    int rd;
    int corr;
    int prev;
    int target;
    rd = reading;
    if (!ok || rd < win_min || rd > win_max) begin
      res.valid = has_value;
    end else begin
      corr = rd + offset;
      if (corr > win_max) corr = win_max;
      if (corr > TEMP_MAX) corr = TEMP_MAX;
      if (corr < TEMP_MIN) corr = TEMP_MIN;
      prev = smooth_value;
      if (warm_count < warmup) begin
        // warm-up: pairwise average, result not yet valid
        warm_count++;
        smooth_value = has_value ? (prev + corr) / 2 : corr;
        res.valid = 1'b0;
      end else begin
        if (!has_value) begin
          smooth_value = corr;
        end else begin
          target = (prev * 7 + corr) / 8;
          if (target > prev + step_limit) smooth_value = prev + step_limit;
          else if (target + step_limit < prev) smooth_value = prev - step_limit;
          else smooth_value = target;
        end
        res.valid = 1'b1;
      end
      has_value = 1'b1;
    end
    res.value = res.valid ? temp_t'(smooth_value) : '0;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= 40)
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // result check first: a word accepted on this edge cannot be the result
  // of a word accepted on the same edge
  always @(posedge clk) begin
    smooth_result_t want;
    temp_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[TEMP_WIDTH-1:0];
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result word, smoothed_x10", got, 0);
        end else begin
          want = results_due.pop_front();
          results_checked++;
          if (got !== want.value) report_mismatch("smoothed_x10", got, want.value);
          if (out_tuser !== want.valid) report_mismatch("smoothed_valid", out_tuser, want.valid);
        end
      end
      if (in_tvalid && in_tready)
        results_due.push_back(smooth_next(temp_t'(in_tdata[TEMP_WIDTH-1:0]), in_tuser));
    end
  end

  // result side ready, with random back-pressure and requested long holds
  always @(negedge clk) begin
    if (hold_left == 0 && hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= 17);
    end
  end

  task automatic send_reading(int r, bit ok);
    while (!quiet && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(TDATA_WIDTH - TEMP_WIDTH){1'b0}}, r[TEMP_WIDTH-1:0]};
    in_tuser <= ok;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    readings_sent++;
  endtask

  task automatic drain(int limit);
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (results_due.size() != 0 && waited < limit) begin
      @(negedge clk);
      waited++;
    end
    if (results_due.size() != 0) begin
      report_mismatch("results never delivered, count", 0, results_due.size());
      results_due.delete();
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_WIDTH-1:0] idx, int value);
    temp_t t;
    ofs_t o;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    t = value[TEMP_WIDTH-1:0];
    o = value[OFS_WIDTH-1:0];
    case (idx)
      REG_VALID_MIN: win_min = t;
      REG_VALID_MAX: win_max = t;
      REG_OFFSET:    offset = o;
      REG_WARMUP:    warmup = value & ((1 << CNT_WIDTH) - 1);
      REG_MAX_STEP:  step_limit = value & ((1 << STEP_WIDTH) - 1);
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic check_reg(logic [REG_IDX_WIDTH-1:0] idx, int width, int want);
    int mask;
    int got;
    mask = (1 << width) - 1;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if ((got & mask) != (want & mask)) report_mismatch("register readback", got & mask, want & mask);
  endtask

  task automatic set_all(int vmin, int vmax, int ofs, int warm, int step);
    write_reg(REG_VALID_MIN, vmin);
    write_reg(REG_VALID_MAX, vmax);
    write_reg(REG_OFFSET, ofs);
    write_reg(REG_WARMUP, warm);
    write_reg(REG_MAX_STEP, step);
    settings_run++;
  endtask

  // reset values: warm-up from an empty store, window edges, rejects
  task automatic test_reset_values();
    send_reading(300, 1'b0);
    send_reading(200, 1'b1);
    send_reading(450, 1'b1);
    send_reading(199, 1'b1);
    send_reading(451, 1'b1);
    send_reading(360, 1'b1);
    send_reading(250, 1'b1);
    drain(2000);
    settings_run++;
  endtask

  task automatic test_register_access();
    set_all(TEMP_MIN, TEMP_MAX, -128, 0, 255);
    check_reg(REG_VALID_MIN, TEMP_WIDTH, TEMP_MIN);
    check_reg(REG_VALID_MAX, TEMP_WIDTH, TEMP_MAX);
    check_reg(REG_OFFSET, OFS_WIDTH, -128);
    check_reg(REG_WARMUP, CNT_WIDTH, 0);
    check_reg(REG_MAX_STEP, STEP_WIDTH, 255);
  endtask

  task automatic test_field_extremes();
    // negative offset pushes the corrected value below the field range
    send_reading(TEMP_MIN, 1'b1);
    send_reading(TEMP_MAX, 1'b1);
    send_reading(TEMP_MIN, 1'b0);
    send_reading(0, 1'b1);
    drain(2000);
    write_reg(REG_OFFSET, 127);
    send_reading(TEMP_MAX, 1'b1);
    send_reading(1920, 1'b1);
    drain(2000);
    write_reg(REG_VALID_MAX, 1000);
    send_reading(1000, 1'b1);
    drain(2000);
    write_reg(REG_MAX_STEP, 0);
    send_reading(-500, 1'b1);
    drain(2000);
    // min above max: nothing gets through
    write_reg(REG_VALID_MIN, 100);
    write_reg(REG_VALID_MAX, -100);
    send_reading(0, 1'b1);
    send_reading(100, 1'b1);
    send_reading(-100, 1'b1);
    drain(2000);
    // warm-up resumes with a stored value
    set_all(-550, 1250, 0, 15, 3);
    send_reading(300, 1'b1);
    send_reading(1250, 1'b1);
    send_reading(-550, 1'b1);
    drain(2000);
  endtask

  task automatic random_phase(int vmin, int vmax, int ofs, int warm, int step,
                              int count, bit hold);
    int r;
    int k;
    bit ok;
    set_all(vmin, vmax, ofs, warm, step);
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 70 && vmin <= vmax) begin
        r = vmin + int'($urandom_range(vmax - vmin));
        ok = ($urandom_range(19) != 0);
      end else if (k < 85) begin
        case ($urandom_range(3))
          0: r = vmin - 1;
          1: r = vmin;
          2: r = vmax;
          default: r = vmax + 1;
        endcase
        ok = ($urandom_range(7) != 0);
      end else begin
        r = int'($urandom_range(4095)) - 2048;
        ok = ($urandom_range(1) != 0);
      end
      if (hold && i == count / 3) hold_req = 60 + $urandom_range(60);
      send_reading(r, ok);
    end
    drain(5000);
  endtask

  task automatic random_typical(int count);
    int vmin;
    vmin = -550 + int'($urandom_range(1800));
    random_phase(vmin, vmin + int'($urandom_range(1250 - vmin)),
                 int'($urandom_range(200)) - 100, $urandom_range(15),
                 $urandom_range(255), count, 1'b0);
  endtask

  task automatic test_random_readings();
    random_phase(200, 450, 30, 3, 2, 200, 1'b1);
    repeat (3) random_typical(150);
    random_phase(TEMP_MIN, TEMP_MAX, -128, 15, 255, 200, 1'b0);
    random_phase(TEMP_MIN, TEMP_MAX, 127, 0, 0, 150, 1'b0);
    quiet = 1'b1;
    random_phase(-550, 1250, -100, 15, 1, 200, 1'b0);
    quiet = 1'b0;
    random_phase(500, -500, 0, 2, 10, 50, 1'b0);
    random_phase(1250, 1250, 100, 1, 255, 100, 1'b0);
    random_typical(170);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_values();
    test_register_access();
    test_field_extremes();
    test_random_readings();
    drain(5000);
    $display("run covered %0d readings and %0d checked results over %0d settings",
             readings_sent, results_checked, settings_run);
    $display("%0d register writes, %0d mismatches", reg_writes, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
